// File: rtl/core/assert_macros.svh
// Assertion macros shared by the RTL of the matrix engine.
// No dependencies; the macros compile to nothing when SYNTHESIS is defined.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
// The consequent must hold in the same cycle as the antecedent.
`define ASSERT_IMPL(label, clk, rstn, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) \
    else $error("assertion failed");
// The consequent must hold in the cycle after the antecedent.
`define ASSERT_NEXT(label, clk, rstn, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) \
    else $error("assertion failed");
`else
`define ASSERT_IMPL(label, clk, rstn, ante, cons)
`define ASSERT_NEXT(label, clk, rstn, ante, cons)
`endif
`endif

// File: rtl/core/dmma_pkg.sv
// Shared constants, codes, types and helper functions of the matrix engine.
// No dependencies; the arithmetic unit, sequencer, top level and testbench import it.
package dmma_pkg;

  localparam int MAX_DIM     = 8;
  localparam int IDX_W       = 3;
  localparam int DIM_CFG_W   = 4;
  localparam int ELEM_W      = 16;
  localparam int PROD_W      = 2 * ELEM_W;
  localparam int SUM_W       = ELEM_W + 1;
  localparam int ADD_SHIFT   = 8;
  localparam int RES_W       = 35;
  localparam int STORE_DEPTH = MAX_DIM * MAX_DIM;
  localparam int ADDR_W      = (STORE_DEPTH > 1) ? $clog2(STORE_DEPTH) : 1;
  localparam int CFG_W       = 4;
  localparam int CFG_IDX_W   = 2;
  localparam int OP_W        = 2;

  localparam logic [DIM_CFG_W-1:0] DIM_RESET = 4'd8;

  typedef enum logic [OP_W-1:0] {
    OP_LOAD_A  = 2'd0,
    OP_LOAD_B  = 2'd1,
    OP_COMPUTE = 2'd2
  } op_t;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_MODE       = 2'd0,
    REG_ROWS_A     = 2'd1,
    REG_INNER_SIZE = 2'd2,
    REG_COLS_B     = 2'd3
  } cfg_reg_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_ISSUE,
    ST_DRAIN,
    ST_EMIT
  } seq_state_t;

  typedef struct packed {
    logic                 mode;
    logic [DIM_CFG_W-1:0] rows_a;
    logic [DIM_CFG_W-1:0] inner_size;
    logic [DIM_CFG_W-1:0] cols_b;
  } cfg_t;

  // Control that travels with one read pair through the multiply-accumulate unit.
  typedef struct packed {
    logic vld;
    logic first;
    logic last;
    logic add;
  } mac_ctl_t;

  // Request from the sequencer to load the output register.
  typedef struct packed {
    logic             vld;
    logic [IDX_W-1:0] row;
    logic [IDX_W-1:0] col;
    logic             last;
  } emit_t;

  // Highest loop index for a dimension register: zero counts as one, and
  // anything above the maximum counts as the maximum.
  function automatic logic [IDX_W-1:0] dim_last(input logic [DIM_CFG_W-1:0] d);
    if (d == '0) begin
      return '0;
    end else if (int'(d) > MAX_DIM) begin
      return IDX_W'(MAX_DIM - 1);
    end else begin
      return IDX_W'(d - DIM_CFG_W'(1));
    end
  endfunction

  // Row-major store address of one element.
  function automatic logic [ADDR_W-1:0] store_addr(input logic [IDX_W-1:0] row,
                                                   input logic [IDX_W-1:0] col);
    return ADDR_W'(ADDR_W'(row) * ADDR_W'(MAX_DIM) + ADDR_W'(col));
  endfunction

endpackage

// File: rtl/core/dmma_ram.sv
// Generic single-port-write, single-port-read RAM with a registered read.
// No dependencies.
module dmma_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 64
) (
  input  logic                                      clk,
  input  logic                                      we,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  logic [WIDTH-1:0]                          wdata,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic [WIDTH-1:0]                          rdata
);

  logic [WIDTH-1:0] mem_r [DEPTH];

  // Write port and registered read port.
  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[waddr] <= wdata;
    end
    rdata <= mem_r[raddr];
  end

endmodule

// File: rtl/core/dmma_mac.sv
// Shared arithmetic unit: one multiply (or scaled add) and an accumulator.
// Depends on dmma_pkg; its operands come from the registered store reads.
module dmma_mac (
  input  logic                          clk,
  input  logic                          rst_n,
  input  dmma_pkg::mac_ctl_t            issue_ctl,
  input  logic signed [dmma_pkg::ELEM_W-1:0] a_data,
  input  logic signed [dmma_pkg::ELEM_W-1:0] b_data,
  output logic signed [dmma_pkg::RES_W-1:0]  acc,
  output logic                          done
);
  import dmma_pkg::*;

  mac_ctl_t                   rd_ctl_r, rd_ctl_nxt;
  mac_ctl_t                   prod_ctl_r, prod_ctl_nxt;
  logic signed [RES_W-1:0]    prod_r, prod_nxt;
  logic signed [RES_W-1:0]    acc_r, acc_nxt;
  logic                       done_r, done_nxt;
  logic signed [PROD_W-1:0]   mul;
  logic signed [SUM_W-1:0]    sum;
  logic signed [SUM_W+ADD_SHIFT-1:0] sum_scaled;

  // Operand stage: the product of two Q8.8 values, or their sum moved to Q19.16.
  always_comb begin
    mul        = a_data * b_data;
    sum        = SUM_W'(a_data) + SUM_W'(b_data);
    sum_scaled = {sum, ADD_SHIFT'(0)};
    rd_ctl_nxt   = issue_ctl;
    prod_ctl_nxt = rd_ctl_r;
    if (rd_ctl_r.add) begin
      prod_nxt = RES_W'(sum_scaled);
    end else begin
      prod_nxt = RES_W'(mul);
    end
  end

  // Accumulate stage: the first term of an element restarts the sum.
  always_comb begin
    acc_nxt  = acc_r;
    done_nxt = 1'b0;
    if (prod_ctl_r.vld) begin
      acc_nxt  = prod_ctl_r.first ? prod_r : acc_r + prod_r;
      done_nxt = prod_ctl_r.last;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rd_ctl_r   <= '0;
      prod_ctl_r <= '0;
      done_r     <= 1'b0;
    end else begin
      rd_ctl_r   <= rd_ctl_nxt;
      prod_ctl_r <= prod_ctl_nxt;
      done_r     <= done_nxt;
    end
  end

  // Data registers carry no reset.
  always_ff @(posedge clk) begin
    prod_r <= prod_nxt;
    acc_r  <= acc_nxt;
  end

  assign acc  = acc_r;
  assign done = done_r;

endmodule

// File: rtl/core/dmma_seq.sv
// Sequencer that walks the result elements and their inner terms.
// Depends on dmma_pkg; drives the store read addresses and the arithmetic unit.
module dmma_seq (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           start,
  input  dmma_pkg::cfg_t                 cfg,
  input  logic                           acc_done,
  input  logic                           out_free,
  output logic                           busy,
  output logic [dmma_pkg::ADDR_W-1:0]    a_raddr,
  output logic [dmma_pkg::ADDR_W-1:0]    b_raddr,
  output dmma_pkg::mac_ctl_t             mac_ctl,
  output dmma_pkg::emit_t                emit
);
  import dmma_pkg::*;

  seq_state_t       state_r, state_nxt;
  logic             mode_r, mode_nxt;
  logic [IDX_W-1:0] m_last_r, m_last_nxt;
  logic [IDX_W-1:0] n_last_r, n_last_nxt;
  logic [IDX_W-1:0] c_last_r, c_last_nxt;
  logic [IDX_W-1:0] i_r, i_nxt;
  logic [IDX_W-1:0] j_r, j_nxt;
  logic [IDX_W-1:0] k_r, k_nxt;
  logic             term_last;
  logic             elem_last;

  // Read addresses: in add mode both stores are read at the result element.
  always_comb begin
    if (mode_r) begin
      a_raddr = store_addr(i_r, j_r);
      b_raddr = store_addr(i_r, j_r);
    end else begin
      a_raddr = store_addr(i_r, k_r);
      b_raddr = store_addr(k_r, j_r);
    end
  end

  assign term_last = mode_r || (k_r == n_last_r);
  assign elem_last = (i_r == m_last_r) && (j_r == c_last_r);
  assign busy      = (state_r != ST_IDLE);

  // Next state and outputs.
  always_comb begin
    state_nxt  = state_r;
    mode_nxt   = mode_r;
    m_last_nxt = m_last_r;
    n_last_nxt = n_last_r;
    c_last_nxt = c_last_r;
    i_nxt      = i_r;
    j_nxt      = j_r;
    k_nxt      = k_r;
    mac_ctl    = '0;
    emit       = '0;
    unique case (state_r)
      ST_IDLE: begin
        if (start) begin
          mode_nxt   = cfg.mode;
          m_last_nxt = dim_last(cfg.rows_a);
          n_last_nxt = dim_last(cfg.inner_size);
          c_last_nxt = cfg.mode ? dim_last(cfg.inner_size) : dim_last(cfg.cols_b);
          i_nxt      = '0;
          j_nxt      = '0;
          k_nxt      = '0;
          state_nxt  = ST_ISSUE;
        end
      end
      ST_ISSUE: begin
        mac_ctl.vld   = 1'b1;
        mac_ctl.first = (k_r == '0);
        mac_ctl.last  = term_last;
        mac_ctl.add   = mode_r;
        if (term_last) begin
          k_nxt     = '0;
          state_nxt = ST_DRAIN;
        end else begin
          k_nxt = k_r + IDX_W'(1);
        end
      end
      ST_DRAIN: begin
        if (acc_done) begin
          state_nxt = ST_EMIT;
        end
      end
      ST_EMIT: begin
        if (out_free) begin
          emit.vld  = 1'b1;
          emit.row  = i_r;
          emit.col  = j_r;
          emit.last = elem_last;
          if (elem_last) begin
            state_nxt = ST_IDLE;
          end else begin
            state_nxt = ST_ISSUE;
            if (j_r == c_last_r) begin
              j_nxt = '0;
              i_nxt = i_r + IDX_W'(1);
            end else begin
              j_nxt = j_r + IDX_W'(1);
            end
          end
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
      i_r     <= '0;
      j_r     <= '0;
      k_r     <= '0;
    end else begin
      state_r <= state_nxt;
      i_r     <= i_nxt;
      j_r     <= j_nxt;
      k_r     <= k_nxt;
    end
  end

  // Bounds latched at the start of a compute item.
  always_ff @(posedge clk) begin
    mode_r   <= mode_nxt;
    m_last_r <= m_last_nxt;
    n_last_r <= n_last_nxt;
    c_last_r <= c_last_nxt;
  end

endmodule

// File: rtl/core/dense_matrix_mul_add_core.sv
// Top level of the dense matrix multiply/add engine.
// Depends on dmma_pkg, dmma_ram, dmma_mac, dmma_seq and assert_macros.svh.
//
// Usage: input items arrive on in_valid/in_stall. A load item writes one Q8.8
// element of A or B into a row-major store. A compute item emits every
// element of C in row-major order on out_valid/out_stall, with out_last on
// the final one. Configuration (mode and the three dimensions) is to be written
// through cfg_we/cfg_index/cfg_data only while the engine is idle; the block
// itself does not enforce this. Per result element, a compute item reads the
// stores once per inner term in multiply mode (once in add mode); each term
// passes the store read, product register and accumulator, all on a single
// multiply-accumulate unit, and the element then goes through the output
// handover before the next element is issued. in_stall is high for the
// whole of a compute item, so loads wait until it is done.
// Reset: the configuration returns to multiply mode with 8 x 8 x 8 dimensions
// and the sequencer goes idle; the element stores are not cleared.
// A stalled receiver holds the output register and the sequencer waits before
// handing over the next element, so no result is lost.
module dense_matrix_mul_add_core (
  input  logic                                 clk,
  input  logic                                 rst_n,
  input  logic                                 in_valid,
  output logic                                 in_stall,
  input  logic [dmma_pkg::OP_W-1:0]            in_operation,
  input  logic [dmma_pkg::IDX_W-1:0]           in_row_index,
  input  logic [dmma_pkg::IDX_W-1:0]           in_col_index,
  input  logic signed [dmma_pkg::ELEM_W-1:0]   in_element_value,
  output logic                                 out_valid,
  input  logic                                 out_stall,
  output logic signed [dmma_pkg::RES_W-1:0]    out_result_value,
  output logic [dmma_pkg::IDX_W-1:0]           out_row,
  output logic [dmma_pkg::IDX_W-1:0]           out_col,
  output logic                                 out_last,
  input  logic                                 cfg_we,
  input  logic [dmma_pkg::CFG_IDX_W-1:0]       cfg_index,
  input  logic [dmma_pkg::CFG_W-1:0]           cfg_data
);
  import dmma_pkg::*;
  `include "assert_macros.svh"

  cfg_t                      cfg_r, cfg_nxt;
  logic                      in_accept;
  logic                      in_range;
  logic                      start;
  logic                      a_we, b_we;
  logic [ADDR_W-1:0]         waddr;
  logic [ADDR_W-1:0]         a_raddr, b_raddr;
  logic [ELEM_W-1:0]         a_rdata, b_rdata;
  mac_ctl_t                  mac_ctl;
  logic signed [RES_W-1:0]   acc;
  logic                      acc_done;
  logic                      busy;
  logic                      out_free;
  emit_t                     emit;
  logic                      out_valid_r, out_valid_nxt;
  logic signed [RES_W-1:0]   out_value_r;
  logic [IDX_W-1:0]          out_row_r, out_col_r;
  logic                      out_last_r;

  // Configuration register writes; unknown indexes fall through.
  always_comb begin
    cfg_nxt = cfg_r;
    if (cfg_we) begin
      unique case (cfg_reg_t'(cfg_index))
        REG_MODE:       cfg_nxt.mode       = cfg_data[0];
        REG_ROWS_A:     cfg_nxt.rows_a     = DIM_CFG_W'(cfg_data);
        REG_INNER_SIZE: cfg_nxt.inner_size = DIM_CFG_W'(cfg_data);
        REG_COLS_B:     cfg_nxt.cols_b     = DIM_CFG_W'(cfg_data);
        default:        cfg_nxt = cfg_r;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.mode       <= 1'b0;
      cfg_r.rows_a     <= DIM_RESET;
      cfg_r.inner_size <= DIM_RESET;
      cfg_r.cols_b     <= DIM_RESET;
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

  // Input item decode: loads write a store, a compute item starts the sequencer and the reserved operation is dropped.
  assign in_stall  = busy;
  assign in_accept = in_valid && !in_stall;
  assign in_range  = (int'(in_row_index) < MAX_DIM) && (int'(in_col_index) < MAX_DIM);
  assign waddr     = store_addr(in_row_index, in_col_index);

  always_comb begin
    a_we  = 1'b0;
    b_we  = 1'b0;
    start = 1'b0;
    unique case (op_t'(in_operation))
      OP_LOAD_A:  a_we  = in_accept && in_range;
      OP_LOAD_B:  b_we  = in_accept && in_range;
      OP_COMPUTE: start = in_accept;
      default:    start = 1'b0;
    endcase
  end

  dmma_ram #(.WIDTH(ELEM_W), .DEPTH(STORE_DEPTH)) u_a_store (
    .clk   (clk),
    .we    (a_we),
    .waddr (waddr),
    .wdata (in_element_value),
    .raddr (a_raddr),
    .rdata (a_rdata)
  );

  dmma_ram #(.WIDTH(ELEM_W), .DEPTH(STORE_DEPTH)) u_b_store (
    .clk   (clk),
    .we    (b_we),
    .waddr (waddr),
    .wdata (in_element_value),
    .raddr (b_raddr),
    .rdata (b_rdata)
  );

  dmma_seq u_seq (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (start),
    .cfg      (cfg_r),
    .acc_done (acc_done),
    .out_free (out_free),
    .busy     (busy),
    .a_raddr  (a_raddr),
    .b_raddr  (b_raddr),
    .mac_ctl  (mac_ctl),
    .emit     (emit)
  );

  dmma_mac u_mac (
    .clk       (clk),
    .rst_n     (rst_n),
    .issue_ctl (mac_ctl),
    .a_data    (signed'(a_rdata)),
    .b_data    (signed'(b_rdata)),
    .acc       (acc),
    .done      (acc_done)
  );

  // Output register: loaded when empty or being taken in the same cycle.
  assign out_free = !out_valid_r || !out_stall;

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (emit.vld) begin
      out_valid_nxt = 1'b1;
    end else if (!out_stall) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (emit.vld) begin
      out_value_r <= acc;
      out_row_r   <= emit.row;
      out_col_r   <= emit.col;
      out_last_r  <= emit.last;
    end
  end

  assign out_valid        = out_valid_r;
  assign out_result_value = out_value_r;
  assign out_row          = out_row_r;
  assign out_col          = out_col_r;
  assign out_last         = out_last_r;

  // The sequencer only hands over an element when the output register can take it.
  `ASSERT_IMPL(a_emit_free, clk, rst_n, emit.vld, (!out_valid_r || !out_stall))
  // An accumulated element only completes while a compute item is in progress.
  `ASSERT_IMPL(a_done_busy, clk, rst_n, acc_done, busy)
  // Handing over the final element releases the input channel.
  `ASSERT_NEXT(a_last_idle, clk, rst_n, (emit.vld && emit.last), (!busy && out_valid && out_last))

endmodule

// File: sim/dense_matrix_mul_add_core_tb.sv
// Self-checking testbench for dense_matrix_mul_add_core: loads A and B, runs multiply and add
// computes under many dimension settings, and checks every emitted element of C.
// Depends on dmma_pkg and the core RTL only.
module dense_matrix_mul_add_core_tb;
  import dmma_pkg::*;

  localparam int CLK_PERIOD  = 12;
  localparam int LIMIT_CYCLES = 5_000_000;
  localparam int ITEM_TARGET = 320;
  localparam int SETTLE_CYCLES = 16;
  localparam logic [OP_W-1:0] OP_RESERVED = 2'd3;
  localparam logic signed [ELEM_W-1:0] ELEM_MIN = 16'sh8000;
  localparam logic signed [ELEM_W-1:0] ELEM_MAX = 16'sh7fff;

  // One element of C as the block should emit it.
  typedef struct packed {
    logic [RES_W-1:0] value;
    logic [IDX_W-1:0] row;
    logic [IDX_W-1:0] col;
    logic             is_last;
  } c_elem_t;

  logic                     clk;
  logic                     rst_n;
  logic                     in_valid;
  logic                     in_stall;
  logic [OP_W-1:0]          in_operation;
  logic [IDX_W-1:0]         in_row_index;
  logic [IDX_W-1:0]         in_col_index;
  logic signed [ELEM_W-1:0] in_element_value;
  logic                     out_valid;
  logic                     out_stall;
  logic signed [RES_W-1:0]  out_result_value;
  logic [IDX_W-1:0]         out_row;
  logic [IDX_W-1:0]         out_col;
  logic                     out_last;
  logic                     cfg_we;
  logic [CFG_IDX_W-1:0]     cfg_index;
  logic [CFG_W-1:0]         cfg_data;

  // Predictor state: the two matrices and the configuration as the block holds them.
  logic signed [ELEM_W-1:0] a_mat [STORE_DEPTH];
  logic signed [ELEM_W-1:0] b_mat [STORE_DEPTH];
  logic                     cfg_mode;
  logic [DIM_CFG_W-1:0]     cfg_rows;
  logic [DIM_CFG_W-1:0]     cfg_inner;
  logic [DIM_CFG_W-1:0]     cfg_cols;

  c_elem_t c_elems_due[$];
  int      items_sent;
  int      loads_sent;
  int      computes;
  int      elems_checked;
  int      mismatches;
  bit      send_burst;

  dense_matrix_mul_add_core DUT (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_valid         (in_valid),
    .in_stall         (in_stall),
    .in_operation     (in_operation),
    .in_row_index     (in_row_index),
    .in_col_index     (in_col_index),
    .in_element_value (in_element_value),
    .out_valid        (out_valid),
    .out_stall        (out_stall),
    .out_result_value (out_result_value),
    .out_row          (out_row),
    .out_col          (out_col),
    .out_last         (out_last),
    .cfg_we           (cfg_we),
    .cfg_index        (cfg_index),
    .cfg_data         (cfg_data)
  );

  initial begin
    clk = 1'b0;
    forever #(CLK_PERIOD / 2) clk = ~clk;
  end

  // Hard limit on the run, well above the slowest legal completion.
  initial begin
    #(LIMIT_CYCLES * CLK_PERIOD);
    $display("Verification failed");
    $finish;
  end

  // A zero dimension counts as one and anything above the maximum as the maximum.
  function automatic int eff_dim(input logic [DIM_CFG_W-1:0] d);
    if (d == '0) begin
      return 1;
    end else if (int'(d) > MAX_DIM) begin
      return MAX_DIM;
    end
    return int'(d);
  endfunction

  function automatic logic signed [ELEM_W-1:0] rand_elem();
    case ($urandom_range(0, 7))
      0: return ELEM_MIN;
      1: return ELEM_MAX;
      default: return ELEM_W'($urandom);
    endcase
  endfunction

  // Mostly small sizes, with the full size and out-of-range settings now and then.
  function automatic logic [DIM_CFG_W-1:0] rand_dim();
    case ($urandom_range(0, 9))
      0: return '0;
      1: return DIM_CFG_W'($urandom_range(MAX_DIM + 1, 15));
      2, 3: return DIM_CFG_W'(MAX_DIM);
      default: return DIM_CFG_W'($urandom_range(1, 4));
    endcase
  endfunction

  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 9);
    if (send_burst || r < 5) begin
      return 0;
    end else if (r < 9) begin
      return $urandom_range(1, 3);
    end
    return $urandom_range(6, 30);
  endfunction

  task automatic report_mismatch(input string what, input longint got, input longint want);
    mismatches++;
    $display("ERROR %s: got %0d, expected %0d (t=%0t)", what, got, want, $time);
  endtask

  // Apply one accepted item to the matrices; a compute queues every element of C.
  task automatic update_matrices(input logic [OP_W-1:0] op, input logic [IDX_W-1:0] row,
                                 input logic [IDX_W-1:0] col,
                                 input logic signed [ELEM_W-1:0] val);
    int      m;
    int      n;
    int      ncols;
    longint  acc;
    c_elem_t elem;
    case (op)
      OP_LOAD_A: a_mat[{row, col}] = val;
      OP_LOAD_B: b_mat[{row, col}] = val;
      OP_COMPUTE: begin
        m = eff_dim(cfg_rows);
        n = eff_dim(cfg_inner);
        ncols = cfg_mode ? n : eff_dim(cfg_cols);
        for (int i = 0; i < m; i++) begin
          for (int j = 0; j < ncols; j++) begin
            acc = 0;
            if (cfg_mode) begin
              // Q8.8 sum moved up to Q19.16.
              acc = (longint'(a_mat[ADDR_W'(i * MAX_DIM + j)]) +
                     longint'(b_mat[ADDR_W'(i * MAX_DIM + j)])) <<< ADD_SHIFT;
            end else begin
              for (int k = 0; k < n; k++) begin
                acc += longint'(a_mat[ADDR_W'(i * MAX_DIM + k)]) *
                       longint'(b_mat[ADDR_W'(k * MAX_DIM + j)]);
              end
            end
            elem.value   = acc[RES_W-1:0];
            elem.row     = IDX_W'(i);
            elem.col     = IDX_W'(j);
            elem.is_last = (i == m - 1) && (j == ncols - 1);
            c_elems_due.push_back(elem);
          end
        end
        computes++;
      end
      default: ;
    endcase
  endtask

  // Present one item after a random gap and hold it until it is taken.
  task automatic send_item(input logic [OP_W-1:0] op, input logic [IDX_W-1:0] row,
                           input logic [IDX_W-1:0] col, input logic signed [ELEM_W-1:0] val);
    int gap;
    gap = pick_gap();
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid         <= 1'b1;
    in_operation     <= op;
    in_row_index     <= row;
    in_col_index     <= col;
    in_element_value <= val;
    @(posedge clk);
    while (in_stall !== 1'b0) @(posedge clk);
    update_matrices(op, row, col, val);
    if (op != OP_RESERVED) begin
      items_sent++;
    end
    if (op == OP_LOAD_A || op == OP_LOAD_B) begin
      loads_sent++;
    end
  endtask

  // Hold off the sender until every due element of C has been taken.
  task automatic drain_results();
    if (c_elems_due.size() != 0) begin
      in_valid <= 1'b0;
      while (c_elems_due.size() != 0) @(posedge clk);
    end
  endtask

  task automatic wait_idle();
    drain_results();
    in_valid <= 1'b0;
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // Write all four registers on back-to-back cycles; only call while idle.
  task automatic set_config(input logic [CFG_W-1:0] mode_data, input logic [CFG_W-1:0] rows,
                            input logic [CFG_W-1:0] inner, input logic [CFG_W-1:0] cols);
    cfg_reg_t            idx [4];
    logic [CFG_W-1:0]    dat [4];
    idx = '{REG_MODE, REG_ROWS_A, REG_INNER_SIZE, REG_COLS_B};
    dat = '{mode_data, rows, inner, cols};
    for (int r = 0; r < 4; r++) begin
      cfg_we    <= 1'b1;
      cfg_index <= idx[r];
      cfg_data  <= dat[r];
      @(posedge clk);
    end
    cfg_we    <= 1'b0;
    cfg_mode  = mode_data[0];
    cfg_rows  = rows;
    cfg_inner = inner;
    cfg_cols  = cols;
  endtask

  // Fill both stores, then compute at the reset size. Row 0 of A and column 0 of B
  // hold the most negative value and column 1 of B the most positive, so C[0][0]
  // and C[0][1] reach the largest and smallest sums.
  task automatic test_reset_dims();
    logic signed [ELEM_W-1:0] v;
    for (int r = 0; r < MAX_DIM; r++) begin
      for (int c = 0; c < MAX_DIM; c++) begin
        v = (r == 0) ? ELEM_MIN : rand_elem();
        send_item(OP_LOAD_A, IDX_W'(r), IDX_W'(c), v);
        v = (c == 0) ? ELEM_MIN : ((c == 1) ? ELEM_MAX : rand_elem());
        send_item(OP_LOAD_B, IDX_W'(r), IDX_W'(c), v);
      end
    end
    send_item(OP_COMPUTE, IDX_W'($urandom), IDX_W'($urandom), rand_elem());
    wait_idle();
  endtask

  // Single-element extremes, the reserved operation, zero and oversized dimensions.
  task automatic test_directed();
    set_config(4'b1110, 4'd1, 4'd1, 4'd1);
    send_item(OP_LOAD_A, '0, '0, ELEM_MAX);
    send_item(OP_LOAD_B, '0, '0, ELEM_MAX);
    send_item(OP_COMPUTE, '0, '0, '0);
    // The reserved operation must leave the stores untouched.
    send_item(OP_RESERVED, '1, '1, ELEM_MIN);
    send_item(OP_COMPUTE, '1, '1, ELEM_MIN);
    wait_idle();
    set_config(4'b1111, 4'd0, 4'd0, 4'd15);
    send_item(OP_COMPUTE, '0, '1, ELEM_MAX);
    send_item(OP_LOAD_A, '0, '0, ELEM_MIN);
    send_item(OP_LOAD_B, '0, '0, ELEM_MIN);
    send_item(OP_COMPUTE, '1, '0, '0);
    wait_idle();
    set_config(4'b0001, 4'd15, 4'd15, 4'd0);
    send_item(OP_COMPUTE, '0, '0, '0);
    wait_idle();
    set_config(4'b0000, 4'd2, 4'd15, 4'd0);
    send_item(OP_COMPUTE, '0, '0, '0);
    wait_idle();
  endtask

  // Random phases: an optional new setting, loads mostly inside the region the next
  // compute reads, some reserved items as noise, then the compute itself.
  task automatic test_random_phases();
    int              phase;
    int              n_loads;
    int              row_lim;
    int              col_lim;
    logic [OP_W-1:0] op;
    logic [IDX_W-1:0] row;
    logic [IDX_W-1:0] col;
    phase = 0;
    while (items_sent < ITEM_TARGET) begin
      if ($urandom_range(0, 2) != 0) begin
        wait_idle();
        set_config(CFG_W'($urandom), rand_dim(), rand_dim(), rand_dim());
      end else if (phase == 2 || $urandom_range(0, 4) == 0) begin
        drain_results();
      end
      send_burst = ($urandom_range(0, 3) == 0);
      n_loads = $urandom_range(0, 12);
      repeat (n_loads) begin
        op = $urandom_range(0, 1) ? OP_LOAD_B : OP_LOAD_A;
        if (op == OP_LOAD_B && !cfg_mode) begin
          row_lim = eff_dim(cfg_inner);
          col_lim = eff_dim(cfg_cols);
        end else begin
          row_lim = eff_dim(cfg_rows);
          col_lim = eff_dim(cfg_inner);
        end
        if ($urandom_range(0, 4) == 0) begin
          row = IDX_W'($urandom);
          col = IDX_W'($urandom);
        end else begin
          row = IDX_W'($urandom_range(0, row_lim - 1));
          col = IDX_W'($urandom_range(0, col_lim - 1));
        end
        if ($urandom_range(0, 9) == 0) begin
          send_item(OP_RESERVED, IDX_W'($urandom), IDX_W'($urandom), rand_elem());
        end
        send_item(op, row, col, rand_elem());
      end
      send_item(OP_COMPUTE, IDX_W'($urandom), IDX_W'($urandom), rand_elem());
      phase++;
    end
    send_burst = 1'b0;
  endtask

  // Receiver back-pressure: short stalls mostly, a few long ones, and quiet stretches.
  initial begin : stall_gen
    int free_len;
    int stall_len;
    forever begin
      free_len  = ($urandom_range(0, 5) == 0) ? $urandom_range(50, 150)
                                              : $urandom_range(1, 6);
      stall_len = ($urandom_range(0, 9) == 0) ? $urandom_range(8, 40)
                                              : $urandom_range(1, 3);
      out_stall <= 1'b0;
      repeat (free_len) @(posedge clk);
      out_stall <= 1'b1;
      repeat (stall_len) @(posedge clk);
    end
  end

  // Compare every taken element of C with the oldest one due.
  always @(posedge clk) begin : result_check
    c_elem_t want;
    if (rst_n && out_valid === 1'b1 && out_stall === 1'b0) begin
      elems_checked++;
      if (c_elems_due.size() == 0) begin
        report_mismatch("element of C with none due", longint'(out_result_value), 0);
      end else begin
        want = c_elems_due.pop_front();
        if (out_result_value !== want.value) begin
          report_mismatch("result value", longint'(out_result_value),
                          longint'($signed(want.value)));
        end
        if (out_row !== want.row) begin
          report_mismatch("row", longint'(out_row), longint'(want.row));
        end
        if (out_col !== want.col) begin
          report_mismatch("column", longint'(out_col), longint'(want.col));
        end
        if (out_last !== want.is_last) begin
          report_mismatch("last flag", longint'(out_last), longint'(want.is_last));
        end
      end
    end
  end

  initial begin
    rst_n            <= 1'b0;
    in_valid         <= 1'b0;
    in_operation     <= OP_LOAD_A;
    in_row_index     <= '0;
    in_col_index     <= '0;
    in_element_value <= '0;
    cfg_we           <= 1'b0;
    cfg_index        <= REG_MODE;
    cfg_data         <= '0;
    cfg_mode         = 1'b0;
    cfg_rows         = DIM_RESET;
    cfg_inner        = DIM_RESET;
    cfg_cols         = DIM_RESET;
    items_sent       = 0;
    loads_sent       = 0;
    computes         = 0;
    elems_checked    = 0;
    mismatches       = 0;
    send_burst       = 1'b0;
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;

    test_reset_dims();
    test_directed();
    test_random_phases();

    // Let the last compute finish and give stray elements a chance to show.
    drain_results();
    repeat (SETTLE_CYCLES) @(posedge clk);
    $display("Sent %0d items: %0d loads and %0d computes; %0d elements of C checked.",
             items_sent, loads_sent, computes, elems_checked);
    $display("Multiply and add modes ran with dimensions from one to eight, zero and oversized.");
    if (mismatches == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule
